### rtl/core/vtyp_pkg.sv
package vtyp_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int ANGLE_FRAC_BITS = 7;

  // difference width before and after range reduction
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int LIM_BITS = 24;
  localparam int D_W      = LIM_BITS + 1;
  localparam int EXT_W    = (DIFF_W > D_W) ? DIFF_W : D_W;
  localparam int MAX_HALF = EXT_W - LIM_BITS;
  localparam int K_W      = $clog2(MAX_HALF + 1);

  // horizontal length: floor(sqrt((dx^2 + dy^2) << 12))
  localparam int SQ_W     = 2 * LIM_BITS;
  localparam int H_SHIFT  = 12;
  localparam int ROOT_W   = (SQ_W + 1 + H_SHIFT + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;

  // cordic datapath
  localparam int V_W          = 34;
  localparam int Z_W          = 26;
  localparam int CORDIC_STEPS = 22;
  localparam int NORM_TOP     = 30;
  localparam int NORM_CELLS   = 5;
  localparam int ZSCALE_BITS  = 16;
  localparam int PITCH_SCALE  = 6;

  localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
  localparam int YAW_W   = ANGLE_FRAC_BITS + 9;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] from_x;
    logic signed [COORD_WIDTH-1:0] from_y;
    logic signed [COORD_WIDTH-1:0] from_z;
    logic signed [COORD_WIDTH-1:0] to_x;
    logic signed [COORD_WIDTH-1:0] to_y;
    logic signed [COORD_WIDTH-1:0] to_z;
  } operands_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [YAW_W-1:0]   yaw_angle;
  } results_t;

  typedef struct packed {
    logic                  yaw_zero;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dz;
  } sq_side_t;

  typedef struct packed {
    logic signed [V_W-1:0] x;
    logic signed [V_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t yaw;
    vec_t pitch;
    logic yaw_zero;
  } angle_state_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = Z_W'(2949120);
      1:  r = Z_W'(1740967);
      2:  r = Z_W'(919879);
      3:  r = Z_W'(466945);
      4:  r = Z_W'(234379);
      5:  r = Z_W'(117304);
      6:  r = Z_W'(58666);
      7:  r = Z_W'(29335);
      8:  r = Z_W'(14668);
      9:  r = Z_W'(7334);
      10: r = Z_W'(3667);
      11: r = Z_W'(1833);
      12: r = Z_W'(917);
      13: r = Z_W'(458);
      14: r = Z_W'(229);
      15: r = Z_W'(115);
      16: r = Z_W'(57);
      17: r = Z_W'(29);
      18: r = Z_W'(14);
      19: r = Z_W'(7);
      20: r = Z_W'(4);
      21: r = Z_W'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/vector_to_yaw_pitch_unit.sv
// channel   | signals             | transfer
// ----------+---------------------+-------------------------------------
// operands  | start, busy, operands | start high while busy low
// result    | done, result        | one-cycle strobe, no backpressure
//
// one transaction per cycle; the stages are difference, range reduction,
// squaring, sum, 31 square-root cells, pre-rotation, 5 normalizing cells,
// 22 cordic cells and the output register.
// a zero difference vector is dropped at range reduction and never strobes done.
// synchronous reset clears all valid bits; busy is a registered copy of rst.
// results cannot be held off, so nothing in the pipeline ever stalls.
module vector_to_yaw_pitch_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  vtyp_pkg::operands_t operands,
  output logic                done,
  output vtyp_pkg::results_t  result
);
  import vtyp_pkg::*;

  localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(180 * 65536);
  localparam int RND_S = ZSCALE_BITS - ANGLE_FRAC_BITS;
  localparam int R_W   = Z_W + 2;
  localparam logic signed [R_W-1:0] HALF_LSB  = R_W'(1) <<< (RND_S - 1);
  localparam logic signed [R_W-1:0] HALF_TURN = R_W'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [R_W-1:0] PITCH_LIM = R_W'(89) <<< ANGLE_FRAC_BITS;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // stage 1: differences
  logic                     v1;
  logic signed [DIFF_W-1:0] dx1, dy1, dz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    dx1 <= DIFF_W'(operands.to_x) - DIFF_W'(operands.from_x);
    dy1 <= DIFF_W'(operands.to_y) - DIFF_W'(operands.from_y);
    dz1 <= DIFF_W'(operands.to_z) - DIFF_W'(operands.from_z);
  end

  // stage 2: halve toward zero until every magnitude is below 2^24
  logic signed [EXT_W-1:0] ex, ey, ez;
  logic [EXT_W-1:0]        mx, my, mz, mall;
  logic [K_W-1:0]          kh;
  logic [EXT_W-1:0]        sx, sy, sz;
  logic                    v2;
  sq_side_t                s2;

  always_comb begin
    ex = EXT_W'(dx1);
    ey = EXT_W'(dy1);
    ez = EXT_W'(dz1);
    mx = ex[EXT_W-1] ? -ex : ex;
    my = ey[EXT_W-1] ? -ey : ey;
    mz = ez[EXT_W-1] ? -ez : ez;
    mall = mx | my | mz;
    kh = '0;
    for (int j = 1; j <= MAX_HALF; j++) begin
      if (mall[LIM_BITS + j - 1]) begin
        kh = K_W'(j);
      end
    end
    sx = mx >> kh;
    sy = my >> kh;
    sz = mz >> kh;
    if (ex[EXT_W-1]) sx = -sx;
    if (ey[EXT_W-1]) sy = -sy;
    if (ez[EXT_W-1]) sz = -sz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1 && ((dx1 != '0) || (dy1 != '0) || (dz1 != '0));
    end
    s2.dx       <= sx[D_W-1:0];
    s2.dy       <= sy[D_W-1:0];
    s2.dz       <= sz[D_W-1:0];
    s2.yaw_zero <= (sx == '0) && (sy == '0);
  end

  // stage 3: squares
  logic                    v3;
  sq_side_t                s3;
  logic [SQ_W-1:0]         qx, qy;
  logic signed [2*D_W-1:0] px2, py2;

  assign px2 = s2.dx * s2.dx;
  assign py2 = s2.dy * s2.dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    qx <= px2[SQ_W-1:0];
    qy <= py2[SQ_W-1:0];
    s3 <= s2;
  end

  // stage 4: radicand
  logic             v4;
  sq_side_t         s4;
  logic [RAD_W-1:0] rad4;
  logic [SQ_W:0]    qsum;

  assign qsum = {1'b0, qx} + {1'b0, qy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    rad4 <= RAD_W'({qsum, {H_SHIFT{1'b0}}});
    s4   <= s3;
  end

  // square-root chain
  logic             sq_v    [ROOT_W+1];
  logic [RAD_W-1:0] sq_rad  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [REM_W-1:0] sq_rem  [ROOT_W+1];
  sq_side_t         sq_side [ROOT_W+1];

  assign sq_v[0]    = v4;
  assign sq_rad[0]  = rad4;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = s4;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    vtyp_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (sq_v[i]),
      .rad_in    (sq_rad[i]),
      .root_in   (sq_root[i]),
      .rem_in    (sq_rem[i]),
      .side_in   (sq_side[i]),
      .valid_out (sq_v[i+1]),
      .rad_out   (sq_rad[i+1]),
      .root_out  (sq_root[i+1]),
      .rem_out   (sq_rem[i+1]),
      .side_out  (sq_side[i+1])
    );
  end

  // pre-rotation: fold the left half-plane onto the right
  sq_side_t              sf;
  logic signed [V_W-1:0] yx0, yy0;
  angle_state_t          pre, pre_r;
  logic                  vpre;

  assign sf = sq_side[ROOT_W];

  always_comb begin
    yx0 = V_W'(sf.dx);
    yy0 = V_W'(sf.dy);
    pre.yaw.x = yx0;
    pre.yaw.y = yy0;
    pre.yaw.z = '0;
    if (yx0[V_W-1]) begin
      pre.yaw.x = -yx0;
      pre.yaw.y = -yy0;
      pre.yaw.z = yy0[V_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
    end
    pre.pitch.x  = V_W'(sq_root[ROOT_W]);
    pre.pitch.y  = V_W'(sf.dz) <<< PITCH_SCALE;
    pre.pitch.z  = '0;
    pre.yaw_zero = sf.yaw_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpre <= 1'b0;
    end else begin
      vpre <= sq_v[ROOT_W];
    end
    pre_r <= pre;
  end

  // normalizing and cordic chains
  localparam int ANG_CELLS = NORM_CELLS + CORDIC_STEPS;

  logic         an_v  [ANG_CELLS+1];
  angle_state_t an_st [ANG_CELLS+1];

  assign an_v[0]  = vpre;
  assign an_st[0] = pre_r;

  for (genvar j = 0; j < NORM_CELLS; j++) begin : g_norm
    vtyp_norm_cell #(.SHIFT(1 << (NORM_CELLS - 1 - j))) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (an_v[j]),
      .st_in     (an_st[j]),
      .valid_out (an_v[j+1]),
      .st_out    (an_st[j+1])
    );
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    vtyp_cordic_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (an_v[NORM_CELLS+k]),
      .st_in     (an_st[NORM_CELLS+k]),
      .valid_out (an_v[NORM_CELLS+k+1]),
      .st_out    (an_st[NORM_CELLS+k+1])
    );
  end

  // rounding, wrap and clamp
  angle_state_t          fin;
  logic signed [R_W-1:0] yaw_r, pitch_r;
  results_t              res_next;

  assign fin = an_st[ANG_CELLS];

  always_comb begin
    yaw_r   = (R_W'(fin.yaw.z) + HALF_LSB) >>> RND_S;
    pitch_r = (-R_W'(fin.pitch.z) + HALF_LSB) >>> RND_S;
    if (yaw_r > HALF_TURN) yaw_r = yaw_r - (HALF_TURN <<< 1);
    if (yaw_r < -HALF_TURN) yaw_r = yaw_r + (HALF_TURN <<< 1);
    if (fin.yaw_zero) yaw_r = '0;
    if (pitch_r > PITCH_LIM) pitch_r = PITCH_LIM;
    if (pitch_r < -PITCH_LIM) pitch_r = -PITCH_LIM;
    res_next.pitch_angle = pitch_r[PITCH_W-1:0];
    res_next.yaw_angle   = yaw_r[YAW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= an_v[ANG_CELLS];
    end
    result <= res_next;
  end

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.yaw_angle <= YAW_W'(HALF_TURN))
              && (result.yaw_angle >= -YAW_W'(HALF_TURN))))
    else $error("yaw outside half turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.pitch_angle <= PITCH_W'(PITCH_LIM))
              && (result.pitch_angle >= -PITCH_W'(PITCH_LIM))))
    else $error("pitch outside clamp");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_zero_dropped: assert property (@(posedge clk) disable iff (rst)
    (v1 && (dx1 == '0) && (dy1 == '0) && (dz1 == '0)) |=> !v2)
    else $error("zero vector entered pipeline");

endmodule

### rtl/core/vtyp_sqrt_cell.sv
module vtyp_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid_in,
  input  logic [vtyp_pkg::RAD_W-1:0]   rad_in,
  input  logic [vtyp_pkg::ROOT_W-1:0]  root_in,
  input  logic [vtyp_pkg::REM_W-1:0]   rem_in,
  input  vtyp_pkg::sq_side_t           side_in,
  output logic                         valid_out,
  output logic [vtyp_pkg::RAD_W-1:0]   rad_out,
  output logic [vtyp_pkg::ROOT_W-1:0]  root_out,
  output logic [vtyp_pkg::REM_W-1:0]   rem_out,
  output vtyp_pkg::sq_side_t           side_out
);
  import vtyp_pkg::*;

  logic [REM_W-1:0] rem_s;
  logic [REM_W-1:0] trial;
  logic             fits;

  // one result bit per cell, two radicand bits consumed
  assign rem_s = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
  assign trial = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
  assign fits  = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
    root_out <= {root_in[ROOT_W-2:0], fits};
    rem_out  <= fits ? rem_s - trial : rem_s;
    side_out <= side_in;
  end

endmodule

### rtl/core/vtyp_norm_cell.sv
module vtyp_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  input  vtyp_pkg::angle_state_t st_in,
  output logic                   valid_out,
  output vtyp_pkg::angle_state_t st_out
);
  import vtyp_pkg::*;

  // every one of the SHIFT doublings needs the value below 2^NORM_TOP first
  localparam logic signed [V_W-1:0] LIM_P = V_W'(1) <<< (NORM_TOP + 1 - SHIFT);
  localparam logic signed [V_W-1:0] LIM_N = -LIM_P;

  function automatic vec_t scale(input vec_t v);
    vec_t r;
    logic in_range;
    in_range = (v.x < LIM_P) && (v.x > LIM_N) && (v.y < LIM_P) && (v.y > LIM_N);
    r = v;
    if (in_range) begin
      r.x = v.x <<< SHIFT;
      r.y = v.y <<< SHIFT;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    st_out.yaw      <= scale(st_in.yaw);
    st_out.pitch    <= scale(st_in.pitch);
    st_out.yaw_zero <= st_in.yaw_zero;
  end

endmodule

### rtl/core/vtyp_cordic_cell.sv
module vtyp_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  input  vtyp_pkg::angle_state_t st_in,
  output logic                   valid_out,
  output vtyp_pkg::angle_state_t st_out
);
  import vtyp_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = atan_entry(STEP);

  // one vectoring micro-rotation, shifts round toward minus infinity
  function automatic vec_t rotate(input vec_t v);
    vec_t r;
    logic signed [V_W-1:0] xs;
    logic signed [V_W-1:0] ys;
    xs = v.x >>> STEP;
    ys = v.y >>> STEP;
    if (!v.y[V_W-1]) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + ANG;
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - ANG;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    st_out.yaw      <= rotate(st_in.yaw);
    st_out.pitch    <= rotate(st_in.pitch);
    st_out.yaw_zero <= st_in.yaw_zero;
  end

endmodule
